/* rtl/mbrtu_pkg.sv */
`default_nettype none
package mbrtu_pkg;

	// register store and counts
	localparam int MAX_REGS  = 32;
	localparam int REG_IDX_W = $clog2(MAX_REGS);
	localparam int CNT_W     = 6;
	localparam int POS_W     = 7;
	localparam int TICK_W    = 16;

	// request frame
	localparam int FRAME_BYTES     = 8;
	localparam int TX_POS_W        = $clog2(FRAME_BYTES);
	localparam int TX_CRC_BYTES    = 6;
	localparam int RX_HEADER_BYTES = 3;
	localparam int BIT_W           = 3;

	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;

	// front to back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register bus
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_IDX_SLAVE   = 1'b0;
	localparam logic REG_IDX_TIMEOUT = 1'b1;
	localparam logic [7:0]        SLAVE_RESET   = 8'd1;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd150;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_BYTE,
		OP_TICK
	} op_t;

	typedef enum logic [2:0] {
		KIND_TX      = 3'd0,
		KIND_REG     = 3'd1,
		KIND_DONE    = 3'd2,
		KIND_CRCERR  = 3'd3,
		KIND_TIMEOUT = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_TX_CRC,
		B_TX_EMIT,
		B_RX_CRC,
		B_RD_ADDR,
		B_RD_EMIT,
		B_END
	} back_state_t;

	typedef struct packed {
		op_t              op;
		logic [15:0]      start_address;
		logic [CNT_W-1:0] count;
		logic [7:0]       rx_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]        slave_address;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		kind_t                kind;
		logic [15:0]          data;
		logic [REG_IDX_W-1:0] index;
		logic                 last;
	} result_t;

	// one bit of the reflected crc-16
	function automatic logic [15:0] crc_shift(input logic [15:0] c);
		crc_shift = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
	endfunction

endpackage
`default_nettype wire

/* rtl/mbrtu_ram.sv */
`default_nettype none
module mbrtu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/mbrtu_front.sv */
`default_nettype none
module mbrtu_front
	import mbrtu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       command,
	input  wire logic [15:0]      start_address,
	input  wire logic [CNT_W-1:0] register_count,
	input  wire logic [7:0]       rx_byte,
	output logic                  push_valid,
	input  wire logic             push_ready,
	output req_t                  push_item
);

	logic valid_s1;
	req_t item_s1;
	req_t item_d;
	cmd_t cmd;

	assign cmd = cmd_t'(command);

	// classify and clamp the count
	always_comb begin
		item_d.start_address = start_address;
		item_d.rx_byte       = rx_byte;
		if (register_count == '0) begin
			item_d.count = CNT_W'(1);
		end else if (register_count > CNT_W'(MAX_REGS)) begin
			item_d.count = CNT_W'(MAX_REGS);
		end else begin
			item_d.count = register_count;
		end
		unique case (cmd)
			CMD_START: item_d.op = OP_START;
			CMD_BYTE:  item_d.op = OP_BYTE;
			default:   item_d.op = OP_TICK;
		endcase
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			// unused command code is taken and dropped
			valid_s1 <= in_valid && (cmd != CMD_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/mbrtu_queue.sv */
`default_nettype none
module mbrtu_queue
	import mbrtu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire req_t push_item,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output req_t      pop_item
);

	req_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

/* rtl/mbrtu_back.sv */
`default_nettype none
module mbrtu_back
	import mbrtu_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  pop_valid,
	output logic                       pop_ready,
	input  wire req_t                  pop_item,
	output logic                       ram_we,
	output logic [REG_IDX_W-1:0]       ram_waddr,
	output logic [15:0]                ram_wdata,
	output logic [REG_IDX_W-1:0]       ram_raddr,
	input  wire logic [15:0]           ram_rdata,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output result_t                    out_item
);

	back_state_t          state_q, state_d;
	logic                 phase_q;
	logic [CNT_W-1:0]     n_q;
	logic [POS_W-1:0]     pos_q;
	logic [15:0]          crc_q;
	logic [7:0]           crc_low_q;
	logic [7:0]           hold_q;
	logic [TICK_W-1:0]    elapsed_q;
	logic [15:0]          addr_q;
	logic [TX_POS_W-1:0]  tx_pos_q;
	logic [BIT_W-1:0]     bit_q;
	logic [REG_IDX_W-1:0] rd_idx_q;
	kind_t                end_kind_q;
	logic                 out_valid_q;
	result_t              out_item_q;

	logic             slot_free;
	logic             pop;
	logic [POS_W-1:0] crc_lo_pos;
	logic [POS_W-1:0] off;
	logic             pos_lt;
	logic             pos_eq;
	logic             is_data;
	logic             crc_match;
	logic             timeout_hit;
	logic             last_reg;
	logic             last_bit;
	logic [7:0]       frame_byte;
	logic [15:0]      crc_in;
	logic             emit;
	result_t          emit_item;

	assign slot_free   = !out_valid_q || out_ready;
	assign pop_ready   = state_q == B_IDLE;
	assign pop         = pop_valid && pop_ready;
	assign crc_lo_pos  = POS_W'(RX_HEADER_BYTES) + {n_q, 1'b0};
	assign off         = pos_q - POS_W'(RX_HEADER_BYTES);
	assign pos_lt      = pos_q < crc_lo_pos;
	assign pos_eq      = pos_q == crc_lo_pos;
	assign is_data     = pos_q >= POS_W'(RX_HEADER_BYTES);
	assign crc_match   = {pop_item.rx_byte, crc_low_q} == crc_q;
	assign timeout_hit = elapsed_q >= cfg.timeout_ticks;
	assign last_reg    = {1'b0, rd_idx_q} == (n_q - 1'b1);
	assign last_bit    = bit_q == BIT_W'(7);

	// request frame byte at the current transmit position
	always_comb begin
		unique case (tx_pos_q)
			3'd0: frame_byte = cfg.slave_address;
			3'd1: frame_byte = FUNC_READ_HOLDING;
			3'd2: frame_byte = addr_q[15:8];
			3'd3: frame_byte = addr_q[7:0];
			3'd4: frame_byte = 8'h00;
			3'd5: frame_byte = {2'b00, n_q};
			3'd6: frame_byte = crc_q[7:0];
			3'd7: frame_byte = crc_q[15:8];
		endcase
	end

	// byte enters the crc on the first bit step of a transmit byte
	assign crc_in = (state_q == B_TX_CRC && bit_q == '0) ? (crc_q ^ {8'h00, frame_byte})
		: crc_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					unique case (pop_item.op)
						OP_START: state_d = B_TX_CRC;
						OP_BYTE: begin
							if (phase_q) begin
								if (pos_lt) begin
									state_d = B_RX_CRC;
								end else if (!pos_eq) begin
									state_d = crc_match ? B_RD_ADDR : B_END;
								end
							end
						end
						OP_TICK: begin
							if (phase_q && timeout_hit) begin
								state_d = B_END;
							end
						end
						default: state_d = B_IDLE;
					endcase
				end
			end
			B_TX_CRC: begin
				if (last_bit) begin
					state_d = B_TX_EMIT;
				end
			end
			B_TX_EMIT: begin
				if (slot_free) begin
					if (tx_pos_q == TX_POS_W'(FRAME_BYTES - 1)) begin
						state_d = B_IDLE;
					end else if (tx_pos_q < TX_POS_W'(TX_CRC_BYTES - 1)) begin
						state_d = B_TX_CRC;
					end
				end
			end
			B_RX_CRC: begin
				if (last_bit) begin
					state_d = B_IDLE;
				end
			end
			B_RD_ADDR: state_d = B_RD_EMIT;
			B_RD_EMIT: begin
				if (slot_free) begin
					state_d = last_reg ? B_END : B_RD_ADDR;
				end
			end
			B_END: begin
				if (slot_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		emit      = 1'b0;
		emit_item = '{kind: KIND_TX, data: '0, index: '0, last: 1'b0};
		unique case (state_q)
			B_TX_EMIT: begin
				emit      = slot_free;
				emit_item = '{kind: KIND_TX, data: {8'h00, frame_byte},
					index: REG_IDX_W'(tx_pos_q),
					last: tx_pos_q == TX_POS_W'(FRAME_BYTES - 1)};
			end
			B_RD_EMIT: begin
				emit      = slot_free;
				emit_item = '{kind: KIND_REG, data: ram_rdata, index: rd_idx_q, last: 1'b0};
			end
			B_END: begin
				emit      = slot_free;
				emit_item = '{kind: end_kind_q, data: '0, index: '0, last: 1'b1};
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign ram_we    = pop && pop_item.op == OP_BYTE && phase_q && pos_lt && is_data && off[0];
	assign ram_waddr = off[REG_IDX_W:1];
	assign ram_wdata = {hold_q, pop_item.rx_byte};
	assign ram_raddr = rd_idx_q;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			phase_q     <= 1'b0;
			n_q         <= '0;
			pos_q       <= '0;
			elapsed_q   <= '0;
			tx_pos_q    <= '0;
			bit_q       <= '0;
			rd_idx_q    <= '0;
			end_kind_q  <= KIND_DONE;
			out_valid_q <= 1'b0;
			crc_q       <= CRC_INIT;
		end else begin
			state_q <= state_d;

			if (pop) begin
				unique case (pop_item.op)
					OP_START: begin
						phase_q   <= 1'b1;
						n_q       <= pop_item.count;
						pos_q     <= '0;
						elapsed_q <= '0;
						tx_pos_q  <= '0;
						bit_q     <= '0;
						crc_q     <= CRC_INIT;
					end
					OP_BYTE: begin
						if (phase_q) begin
							if (pos_lt) begin
								crc_q <= crc_q ^ {8'h00, pop_item.rx_byte};
								pos_q <= pos_q + 1'b1;
							end else if (pos_eq) begin
								pos_q <= pos_q + 1'b1;
							end else begin
								phase_q    <= 1'b0;
								pos_q      <= '0;
								rd_idx_q   <= '0;
								end_kind_q <= crc_match ? KIND_DONE : KIND_CRCERR;
							end
						end
					end
					OP_TICK: begin
						if (phase_q) begin
							if (timeout_hit) begin
								phase_q    <= 1'b0;
								pos_q      <= '0;
								end_kind_q <= KIND_TIMEOUT;
							end else begin
								elapsed_q <= elapsed_q + 1'b1;
							end
						end
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end

			// shared bit-serial crc unit
			if (state_q == B_TX_CRC || state_q == B_RX_CRC) begin
				crc_q <= crc_shift(crc_in);
				bit_q <= bit_q + 1'b1;
			end

			if (state_q == B_TX_EMIT && slot_free) begin
				tx_pos_q <= tx_pos_q + 1'b1;
				// running crc of the response starts fresh after the request
				if (tx_pos_q == TX_POS_W'(FRAME_BYTES - 1)) begin
					crc_q <= CRC_INIT;
				end
			end

			if (state_q == B_RD_EMIT && slot_free && !last_reg) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.op == OP_START) begin
			addr_q    <= pop_item.start_address;
			crc_low_q <= 8'h00;
			hold_q    <= 8'h00;
		end
		if (pop && pop_item.op == OP_BYTE && phase_q) begin
			if (pos_lt && is_data && !off[0]) begin
				hold_q <= pop_item.rx_byte;
			end
			if (pos_eq) begin
				crc_low_q <= pop_item.rx_byte;
			end
		end
		if (emit) begin
			out_item_q <= emit_item;
		end
	end

endmodule
`default_nettype wire

/* rtl/modbus_rtu_read_holding_master_unit.sv */
// modbus rtu master for function 03, read holding registers
//
// request channel (in_valid / in_ready): command 0 starts a read of register_count
// registers from start_address, command 1 hands over one received bus byte, command 2
// is one timeout tick; command 3 is taken and dropped. bytes and ticks while no read
// is open are dropped too. a start while a read is open abandons it silently.
// result channel (out_valid / out_ready): 8 transmit bytes per start, then on the
// final response byte either every register value followed by done, or a crc error;
// a tick past timeout_ticks gives a timeout. last marks the final result of a request.
// a request passes a one-stage front and a two-entry queue, so the front keeps taking
// requests while the back is busy. the back runs one bit-serial crc unit: a start is
// taken, then six bytes get 8 crc steps and an emit each, then the two crc bytes are
// emitted; a header or data byte gets 8 crc steps, the low crc byte and a tick are only
// taken, and a matching closing byte releases each register, read from the register ram.
// a stalled receiver holds the output register; the back waits on it and the queue
// and front fill up before in_ready drops.
// reset: slave_address 1, timeout_ticks 150, no read open, queue and output empty.
// registers on the apb port: slave_address at 0, timeout_ticks at 4.
`default_nettype none
module modbus_rtu_read_holding_master_unit
	import mbrtu_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         command,
	input  wire logic [15:0]        start_address,
	input  wire logic [CNT_W-1:0]   register_count,
	input  wire logic [7:0]         rx_byte,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              kind,
	output logic [15:0]             data,
	output logic [REG_IDX_W-1:0]    index,
	output logic                    last
);

	cfg_t    cfg_q;
	logic    reg_sel;
	logic    reg_write;
	logic    push_valid;
	logic    push_ready;
	req_t    push_item;
	logic    pop_valid;
	logic    pop_ready;
	req_t    pop_item;
	logic                 ram_we;
	logic [REG_IDX_W-1:0] ram_waddr;
	logic [15:0]          ram_wdata;
	logic [REG_IDX_W-1:0] ram_raddr;
	logic [15:0]          ram_rdata;
	result_t              result;

	// register file, decoded on the word address bit
	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address <= SLAVE_RESET;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (reg_write) begin
			if (reg_sel == REG_IDX_SLAVE) begin
				cfg_q.slave_address <= pwdata[7:0];
			end else begin
				cfg_q.timeout_ticks <= pwdata[TICK_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == REG_IDX_TIMEOUT) begin
			prdata = PDATA_W'(cfg_q.timeout_ticks);
		end else begin
			prdata = PDATA_W'(cfg_q.slave_address);
		end
	end

	// front: takes and classifies requests
	mbrtu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.start_address  (start_address),
		.register_count (register_count),
		.rx_byte        (rx_byte),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_item      (push_item)
	);

	// short queue decoupling front and back
	mbrtu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// back: framing, crc, register capture and release
	mbrtu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (result)
	);

	// received register values, big-endian assembled
	mbrtu_ram #(
		.WIDTH (16),
		.DEPTH (MAX_REGS)
	) u_reg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign kind  = result.kind;
	assign data  = result.data;
	assign index = result.index;
	assign last  = result.last;

endmodule
`default_nettype wire

/* test/modbus_rtu_read_holding_master_unit_tb.sv */
`timescale 1ns / 1ps
module modbus_rtu_read_holding_master_unit_tb;
	import mbrtu_pkg::*;

	// settle time after the last expected result: covers bytes and ticks still in the
	// front, the queue and the bit-serial crc unit, which give no result of their own
	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_REPORTS   = 10;
	// generous bound: a few thousand requests worth of the slowest path
	localparam int LIMIT_NS      = 2_000_000;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [PADDR_W-1:0] paddr    = '0;
	logic [PDATA_W-1:0] pwdata   = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command        = CMD_NONE;
	logic [15:0]        start_address  = '0;
	logic [CNT_W-1:0]   register_count = '0;
	logic [7:0]         rx_byte        = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         kind;
	logic [15:0]        data;
	logic [REG_IDX_W-1:0] index;
	logic               last;

	modbus_rtu_read_holding_master_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.start_address(start_address),
		.register_count(register_count),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data(data),
		.index(index),
		.last(last)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------
	// master model: configuration and the state of the read in progress
	// ---------------------------------------------------------------------------
	logic [7:0]        cfg_slave   = SLAVE_RESET;
	logic [TICK_W-1:0] cfg_timeout = TIMEOUT_RESET;
	logic              rd_open     = 1'b0;
	logic [CNT_W-1:0]  rd_count    = '0;
	logic [POS_W-1:0]  rd_pos      = '0;
	logic [15:0]       rd_crc      = CRC_INIT;
	logic [7:0]        rd_crc_low  = '0;
	logic [7:0]        rd_high     = '0;
	logic [TICK_W-1:0] rd_ticks    = '0;
	logic [15:0]       reg_image [MAX_REGS];

	// results still owed by the block, oldest first
	result_t expected_results [$];

	int errors     = 0;
	int items_sent = 0;
	// set for the stretch where neither side idles
	bit no_idle    = 1'b0;

	// reflected crc-16, one byte
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// a count of zero reads one register, anything past the store reads the whole store
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] cnt);
		if (cnt == 0)
			return CNT_W'(1);
		if (cnt > MAX_REGS)
			return CNT_W'(MAX_REGS);
		return cnt;
	endfunction

	function automatic void expect_result(input kind_t k, input logic [15:0] d,
			input logic [REG_IDX_W-1:0] idx, input logic l);
		result_t r;
		r.kind  = k;
		r.data  = d;
		r.index = idx;
		r.last  = l;
		expected_results.push_back(r);
	endfunction

	// advance the model by one accepted request and queue what it must produce
	task automatic predict_request(input cmd_t cmd, input logic [15:0] addr,
			input logic [CNT_W-1:0] cnt, input logic [7:0] rxb);
		logic [7:0]       frame [FRAME_BYTES];
		logic [15:0]      crc;
		logic [POS_W-1:0] crc_lo_pos;
		logic [POS_W-1:0] off;
		if (cmd == CMD_START) begin
			// a start always wins, whatever read was open
			frame[0] = cfg_slave;
			frame[1] = FUNC_READ_HOLDING;
			frame[2] = addr[15:8];
			frame[3] = addr[7:0];
			frame[4] = 8'h00;
			frame[5] = {2'b00, clamp_count(cnt)};
			crc = CRC_INIT;
			for (int i = 0; i < TX_CRC_BYTES; i++)
				crc = crc16_step(crc, frame[i]);
			frame[6] = crc[7:0];
			frame[7] = crc[15:8];
			for (int i = 0; i < FRAME_BYTES; i++)
				expect_result(KIND_TX, {8'h00, frame[i]}, REG_IDX_W'(i), i == FRAME_BYTES - 1);
			rd_open    = 1'b1;
			rd_count   = clamp_count(cnt);
			rd_pos     = '0;
			rd_crc     = CRC_INIT;
			rd_crc_low = '0;
			rd_high    = '0;
			rd_ticks   = '0;
		end else if (rd_open && cmd == CMD_BYTE) begin
			crc_lo_pos = POS_W'(RX_HEADER_BYTES + 2 * rd_count);
			if (rd_pos < crc_lo_pos) begin
				// header and data bytes feed the running crc
				rd_crc = crc16_step(rd_crc, rxb);
				if (rd_pos >= RX_HEADER_BYTES) begin
					off = rd_pos - POS_W'(RX_HEADER_BYTES);
					if (!off[0])
						rd_high = rxb;
					else
						reg_image[off[REG_IDX_W:1]] = {rd_high, rxb};
				end
				rd_pos = rd_pos + 1'b1;
			end else if (rd_pos == crc_lo_pos) begin
				rd_crc_low = rxb;
				rd_pos     = rd_pos + 1'b1;
			end else begin
				// closing byte: high half of the received crc
				rd_open = 1'b0;
				rd_pos  = '0;
				if ({rxb, rd_crc_low} != rd_crc) begin
					expect_result(KIND_CRCERR, 16'h0000, '0, 1'b1);
				end else begin
					for (int r = 0; r < rd_count; r++)
						expect_result(KIND_REG, reg_image[r], REG_IDX_W'(r), 1'b0);
					expect_result(KIND_DONE, 16'h0000, '0, 1'b1);
				end
			end
		end else if (rd_open && cmd == CMD_TICK) begin
			if (rd_ticks >= cfg_timeout) begin
				rd_open = 1'b0;
				rd_pos  = '0;
				expect_result(KIND_TIMEOUT, 16'h0000, '0, 1'b1);
			end else begin
				rd_ticks = rd_ticks + 1'b1;
			end
		end
		// bytes and ticks with no read open, and command 3, change nothing
	endtask

	// ---------------------------------------------------------------------------
	// result side: random back-pressure and the scoreboard
	// ---------------------------------------------------------------------------
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(0, 99) >= 31);
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: kind %0d data %h index %0d last %b",
						kind, data, index, last);
			end else begin
				want = expected_results.pop_front();
				if (kind !== want.kind || data !== want.data ||
						index !== want.index || last !== want.last) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display({"mismatch: expected kind %0d data %h index %0d last %b,",
							" got kind %0d data %h index %0d last %b"},
							want.kind, want.data, want.index, want.last,
							kind, data, index, last);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------------------

	// one request: optional idle gap, then hold valid until taken. valid is left high
	// afterwards so back-to-back requests never drop it within a time step
	task automatic send_req(input cmd_t cmd, input logic [15:0] addr,
			input logic [CNT_W-1:0] cnt, input logic [7:0] rxb);
		int gap;
		gap = (!no_idle && $urandom_range(0, 99) < 31) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= cmd;
		start_address  <= addr;
		register_count <= cnt;
		rx_byte        <= rxb;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		predict_request(cmd, addr, cnt, rxb);
	endtask

	// fields a command does not use are randomised, they must not matter
	task automatic send_start(input logic [15:0] addr, input logic [CNT_W-1:0] cnt);
		send_req(CMD_START, addr, cnt, 8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_req(CMD_BYTE, 16'($urandom), CNT_W'($urandom), b);
	endtask

	task automatic send_tick();
		send_req(CMD_TICK, 16'($urandom), CNT_W'($urandom), 8'($urandom));
	endtask

	// slave reply for a read of regs registers; optionally one flipped bit anywhere,
	// optionally ticks sprinkled in, never enough to time out
	task automatic send_response(input logic [CNT_W-1:0] regs, input bit corrupt,
			input bit with_ticks, input bit extremes);
		logic [7:0]  reply [$];
		logic [15:0] crc;
		int          ticks;
		int          hit;
		reply.push_back(cfg_slave);
		reply.push_back(FUNC_READ_HOLDING);
		reply.push_back(8'(2 * regs));
		for (int i = 0; i < 2 * regs; i++)
			reply.push_back(extremes ? ((i % 2) ? 8'h00 : 8'hFF) : 8'($urandom));
		crc = CRC_INIT;
		foreach (reply[i])
			crc = crc16_step(crc, reply[i]);
		reply.push_back(crc[7:0]);
		reply.push_back(crc[15:8]);
		if (corrupt) begin
			hit = $urandom_range(0, reply.size() - 1);
			reply[hit] = reply[hit] ^ (8'h01 << $urandom_range(0, 7));
		end
		ticks = 0;
		foreach (reply[i]) begin
			if (with_ticks && ticks < cfg_timeout && $urandom_range(0, 9) == 0) begin
				send_tick();
				ticks++;
			end
			send_byte(reply[i]);
		end
	endtask

	// hold off new requests until every owed result is out and the block has gone quiet
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write, setup then access; only ever done with the block idle
	task automatic program_register(input logic reg_idx, input logic [PDATA_W-1:0] value);
		drain_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == REG_IDX_SLAVE)
			cfg_slave = value[7:0];
		else
			cfg_timeout = value[TICK_W-1:0];
	endtask

	// mix of complete reads, abandoned reads, timeouts and junk
	task automatic run_random(input int n);
		int               target;
		int               pick;
		int               k;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] regs;
		target = items_sent + n;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			// mostly short reads, now and then any count the field can carry
			cnt  = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 63))
				: CNT_W'($urandom_range(1, 4));
			regs = clamp_count(cnt);
			if (pick < 65) begin
				// well-formed read, sometimes with a damaged reply
				send_start(16'($urandom), cnt);
				send_response(regs, $urandom_range(0, 6) == 0, 1'b1, 1'b0);
			end else if (pick < 75) begin
				// reply cut short, the next start abandons it
				send_start(16'($urandom), cnt);
				k = $urandom_range(0, 4 + 2 * regs);
				repeat (k) send_byte(8'($urandom));
			end else if (pick < 85) begin
				// silent slave: run the clock out when the limit is short
				send_start(16'($urandom), cnt);
				k = (cfg_timeout < 40) ? cfg_timeout + 1 : $urandom_range(1, 5);
				repeat (k) send_tick();
			end else begin
				repeat ($urandom_range(1, 3))
					send_req(cmd_t'($urandom_range(0, 3)), 16'($urandom),
						CNT_W'($urandom), 8'($urandom));
			end
		end
	endtask

	// ---------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------

	// bytes, ticks and the spare command with no read open are all dropped
	task automatic test_idle_noise();
		send_byte(8'($urandom));
		send_tick();
		send_req(CMD_NONE, 16'($urandom), CNT_W'($urandom), 8'($urandom));
	endtask

	// zero count reads one register; register value with all-ones and all-zeros bytes
	task automatic test_single_read();
		send_start(16'h0000, CNT_W'(0));
		send_response(CNT_W'(1), 1'b0, 1'b0, 1'b1);
	endtask

	// top address and a reply with one bad bit
	task automatic test_crc_error();
		send_start(16'hFFFF, CNT_W'(1));
		send_response(CNT_W'(1), 1'b1, 1'b0, 1'b0);
	endtask

	// zero limit times out on the first tick; a limit of two on the third;
	// a tick after the timeout finds no read open
	task automatic test_timeouts();
		program_register(REG_IDX_TIMEOUT, 0);
		send_start(16'($urandom), CNT_W'(2));
		send_tick();
		program_register(REG_IDX_TIMEOUT, 2);
		send_start(16'($urandom), CNT_W'(3));
		repeat (3) send_tick();
		send_tick();
	endtask

	// count above the store clamps to a full read of every register
	task automatic test_widest_read();
		program_register(REG_IDX_SLAVE, 32'h0000_00FF);
		program_register(REG_IDX_TIMEOUT, 32'h0000_FFFF);
		send_start(16'($urandom), CNT_W'(63));
		send_response(CNT_W'(MAX_REGS), 1'b0, 1'b1, 1'b0);
	endtask

	// long stretch with no idling on either side
	task automatic test_random_steady();
		program_register(REG_IDX_SLAVE, $urandom_range(0, 255));
		program_register(REG_IDX_TIMEOUT, PDATA_W'(TIMEOUT_RESET));
		no_idle = 1'b1;
		run_random(12);
		drain_results();
		no_idle = 1'b0;
	endtask

	// slave address zero and a short limit, so silent slaves time out
	task automatic test_random_short_timeout();
		program_register(REG_IDX_SLAVE, 0);
		program_register(REG_IDX_TIMEOUT, 8);
		run_random(6);
	endtask

	task automatic test_random_mixed();
		program_register(REG_IDX_SLAVE, $urandom_range(1, 254));
		program_register(REG_IDX_TIMEOUT, $urandom_range(1, 65535));
		run_random(6);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_noise();
		test_single_read();
		test_crc_error();
		test_timeouts();
		test_widest_read();
		test_random_steady();
		test_random_short_timeout();
		test_random_mixed();
		drain_results();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// hang guard
	initial begin
		#(LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule
